>>> rtl/mpn_pkg.sv
`timescale 1ns / 1ps
package mpn_pkg;
  localparam int MAX_LANES  = 6;
  localparam int SHARE_W    = 8;
  localparam int LANE_W     = 3;
  localparam int PCT_W      = 7;
  localparam int COMP_W     = 16;
  localparam int SUM_W      = 11;
  localparam int DIV_W      = 22;
  localparam int PCT_TOTAL  = 100;
  localparam int LANES_DEF  = 4;
  localparam int FULL_DEF   = 128;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [MAX_LANES-1:0][SHARE_W-1:0] share;
    logic [SUM_W-1:0]                  sum;
  } item_t;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [PCT_W-1:0]  percent;
    logic [COMP_W-1:0] component;
    logic              zero_sum;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;
endpackage

>>> rtl/mpn_fifo.sv
`timescale 1ns / 1ps
module mpn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

>>> rtl/mpn_front.sv
`timescale 1ns / 1ps
module mpn_front #(
  parameter int LANES = 4
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      push,
  output logic                                      full,
  input  logic [mpn_pkg::MAX_LANES-1:0][mpn_pkg::SHARE_W-1:0] share,
  input  logic                                      q_pop,
  output mpn_pkg::item_t                            q_item,
  output logic                                      q_empty
);
  import mpn_pkg::*;

  item_t item;

  always_comb begin
    item.share = share;
    item.sum   = '0;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (i < LANES) begin
        item.sum = item.sum + SUM_W'(share[i]);
      end
    end
  end

  mpn_fifo #(.WIDTH($bits(item_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_item),
    .empty   (q_empty)
  );
endmodule

>>> rtl/mpn_div.sv
`timescale 1ns / 1ps
module mpn_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mpn_pkg::div_req_t req,
  output mpn_pkg::div_rsp_t rsp
);
  import mpn_pkg::*;

  localparam int STEPS = 4;
  localparam int CYC   = (DIV_W + STEPS - 1) / STEPS;
  localparam int PW    = CYC * STEPS;
  localparam int CNW   = $clog2(CYC + 1);

  logic [SUM_W:0]   rem_r, rem_nxt;
  logic [PW-1:0]    quo_r, quo_nxt;
  logic [SUM_W-1:0] dvs_r;
  logic [CNW-1:0]   cnt_r;
  logic             busy_r, done_r;

  // four restoring steps per cycle
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < STEPS; i++) begin
      rem_nxt = {rem_nxt[SUM_W-1:0], quo_nxt[PW-1]};
      quo_nxt = {quo_nxt[PW-2:0], 1'b0};
      if (rem_nxt >= {1'b0, dvs_r}) begin
        rem_nxt    = rem_nxt - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(CYC);
        rem_r  <= '0;
        quo_r  <= PW'(req.dividend);
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[DIV_W-1:0];
endmodule

>>> rtl/mpn_back.sv
`timescale 1ns / 1ps
module mpn_back #(
  parameter int LANES      = 4,
  parameter int FULL_SCALE = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mpn_pkg::item_t q_item,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output mpn_pkg::res_t  res
);
  import mpn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PDIV, S_PWAIT, S_FIX, S_CDIV, S_CWAIT, S_EMIT
  } state_t;

  state_t            state_r;
  item_t             item_r;
  logic [LANE_W-1:0] k_r;
  logic [PCT_W-1:0]  pct_r [MAX_LANES];
  logic [PCT_W-1:0]  top_r;
  logic [COMP_W-1:0] comp_r;
  logic              zero_r;

  logic [PCT_W-1:0]  fix [MAX_LANES];
  logic [PCT_W-1:0]  top;
  logic [7:0]        got, others, rem;
  logic              found;
  logic              last_lane;

  div_req_t dreq;
  div_rsp_t drsp;
  res_t     ores;
  logic     ofull, opush;

  assign last_lane = (k_r == LANE_W'(LANES - 1));

  always_comb begin
    got = '0;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (i < LANES) got = got + 8'(pct_r[i]);
    end
    others = got - 8'(pct_r[LANES-1]);
    rem    = 8'(PCT_TOTAL) - got;
    found  = 1'b0;
    for (int i = 0; i < MAX_LANES; i++) fix[i] = pct_r[i];
    if (got < 8'(PCT_TOTAL)) begin
      if (pct_r[LANES-1] != '0) begin
        fix[LANES-1] = PCT_W'(8'(PCT_TOTAL) - others);
      end else begin
        for (int i = 0; i < MAX_LANES; i++) begin
          if (i < LANES - 1 && !found && fix[i] != '0 &&
              8'(fix[i]) < 8'(PCT_TOTAL) - rem) begin
            fix[i] = fix[i] + PCT_W'(rem);
            found  = 1'b1;
          end
        end
      end
    end
    top = '0;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (i < LANES && fix[i] > top) top = fix[i];
    end
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    if (state_r == S_PDIV) begin
      dreq.start    = 1'b1;
      dreq.dividend = DIV_W'(item_r.share[k_r]) * DIV_W'(PCT_TOTAL);
      dreq.divisor  = item_r.sum;
    end else if (state_r == S_CDIV && top_r != '0) begin
      dreq.start    = 1'b1;
      dreq.dividend = DIV_W'(pct_r[k_r]) * DIV_W'(FULL_SCALE);
      dreq.divisor  = SUM_W'(top_r);
    end
  end

  mpn_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign opush = (state_r == S_EMIT);

  always_comb begin
    ores.lane      = k_r;
    ores.percent   = zero_r ? '0 : pct_r[k_r];
    ores.component = zero_r ? '0 : comp_r;
    ores.zero_sum  = zero_r;
    ores.last      = last_lane;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      zero_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            item_r <= q_item;
            k_r    <= '0;
            zero_r <= (q_item.sum == '0);
            comp_r <= '0;
            state_r <= (q_item.sum == '0) ? S_EMIT : S_PDIV;
          end
        end
        S_PDIV: state_r <= S_PWAIT;
        S_PWAIT: begin
          if (drsp.done) begin
            pct_r[k_r] <= drsp.quotient[PCT_W-1:0];
            if (last_lane) begin
              state_r <= S_FIX;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_PDIV;
            end
          end
        end
        S_FIX: begin
          for (int i = 0; i < MAX_LANES; i++) pct_r[i] <= fix[i];
          top_r   <= top;
          k_r     <= '0;
          state_r <= S_CDIV;
        end
        S_CDIV: begin
          if (top_r == '0) begin
            comp_r  <= '0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (drsp.done) begin
            comp_r  <= drsp.quotient[COMP_W-1:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!ofull) begin
            if (last_lane) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= zero_r ? S_EMIT : S_CDIV;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  mpn_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (opush),
    .wr_data (ores),
    .full    (ofull),
    .rd_en   (pop),
    .rd_data (res),
    .empty   (empty)
  );
endmodule

>>> rtl/mix_percent_normalizer.sv
`timescale 1ns / 1ps
// Mix percent normalizer.
// Input queue side: drive share ports and raise push; the set is taken at a
// clock edge with push high and full low. Only lanes 0..LANES-1 count.
// Result queue side: while empty is low the oldest result (lane, percent,
// component, zero_sum, last) sits on the ports; pop takes it. Each set
// yields LANES results in lane order, last marks the final lane.
// A two-entry queue separates the summing front end from the sequencer, so
// new sets are taken while results are still being produced.
// Each lane of a set with a nonzero sum needs two divisions on one shared
// divider that retires four quotient bits a cycle; an all-zero set needs no
// division. When pop stays low the two-entry result queue fills, the
// sequencer holds, and after the input queue fills, full rises. Reset
// empties both queues and returns the sequencer to idle.
module mix_percent_normalizer #(
  parameter int LANES      = mpn_pkg::LANES_DEF,
  parameter int FULL_SCALE = mpn_pkg::FULL_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [mpn_pkg::SHARE_W-1:0] in_share_0,
  input  logic [mpn_pkg::SHARE_W-1:0] in_share_1,
  input  logic [mpn_pkg::SHARE_W-1:0] in_share_2,
  input  logic [mpn_pkg::SHARE_W-1:0] in_share_3,
  input  logic [mpn_pkg::SHARE_W-1:0] in_share_4,
  input  logic [mpn_pkg::SHARE_W-1:0] in_share_5,
  output logic                        empty,
  input  logic                        pop,
  output logic [mpn_pkg::LANE_W-1:0]  out_lane,
  output logic [mpn_pkg::PCT_W-1:0]   out_percent,
  output logic [mpn_pkg::COMP_W-1:0]  out_component,
  output logic                        out_zero_sum,
  output logic                        out_last
);
  import mpn_pkg::*;

  logic [MAX_LANES-1:0][SHARE_W-1:0] share;
  item_t q_item;
  logic  q_empty, q_pop;
  res_t  res;

  assign share = {in_share_5, in_share_4, in_share_3, in_share_2, in_share_1, in_share_0};

  mpn_front #(.LANES(LANES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .share   (share),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .q_empty (q_empty)
  );

  mpn_back #(.LANES(LANES), .FULL_SCALE(FULL_SCALE)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_lane      = res.lane;
  assign out_percent   = res.percent;
  assign out_component = res.component;
  assign out_zero_sum  = res.zero_sum;
  assign out_last      = res.last;
endmodule

>>> rtl/mpn_checker.sv
`timescale 1ns / 1ps
module mpn_checker #(
  parameter int LANES      = 4,
  parameter int FULL_SCALE = 128
) (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic [2:0] out_lane,
  input logic [6:0] out_percent,
  input logic [15:0] out_component,
  input logic       out_zero_sum,
  input logic       out_last
);
  a_last_lane: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_last == (out_lane == 3'(LANES - 1))))
    else $error("last flag does not match lane");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_zero_sum) |-> (out_percent == '0 && out_component == '0))
    else $error("zero sum result not zero");

  a_pct: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_percent <= 7'd100 && out_lane < 3'(LANES)))
    else $error("percent or lane out of range");

  a_comp: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (32'(out_component) <= 32'(FULL_SCALE)))
    else $error("component above full scale");
endmodule

bind mix_percent_normalizer mpn_checker #(.LANES(LANES), .FULL_SCALE(FULL_SCALE)) u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .empty         (empty),
  .out_lane      (out_lane),
  .out_percent   (out_percent),
  .out_component (out_component),
  .out_zero_sum  (out_zero_sum),
  .out_last      (out_last)
);

>>> bench/tb_mix_percent_normalizer.sv
`timescale 1ns / 1ps
module tb_mix_percent_normalizer;
  import mpn_pkg::*;

  localparam int LANES = LANES_DEF;
  localparam int FULL  = FULL_DEF;

  typedef struct {
    logic [LANE_W-1:0] lane;
    logic [PCT_W-1:0]  percent;
    logic [COMP_W-1:0] component;
    logic              zero_sum;
    logic              last;
  } lane_res_t;

  class mix_scoreboard;
    lane_res_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_set(logic [SHARE_W-1:0] sh[MAX_LANES]);
      int unsigned pct[MAX_LANES];
      int unsigned total, got, others, rem, top;
      bit zero;
      lane_res_t r;
      total = 0;
      got = 0;
      others = 0;
      top = 0;
      for (int k = 0; k < LANES; k++) begin
        pct[k] = 32'(sh[k]);
        total += pct[k];
      end
      zero = (total == 0);
      if (!zero) begin
        for (int k = 0; k < LANES; k++) begin
          pct[k] = pct[k] * PCT_TOTAL / total;
          got += pct[k];
        end
        if (got < PCT_TOTAL) begin
          for (int k = 0; k < LANES - 1; k++) others += pct[k];
          if (pct[LANES-1] > 0) begin
            pct[LANES-1] = PCT_TOTAL - others;
          end else begin
            rem = PCT_TOTAL - got;
            for (int k = 0; k < LANES - 1; k++) begin
              if (pct[k] > 0 && pct[k] < PCT_TOTAL - rem) begin
                pct[k] += rem;
                break;
              end
            end
          end
        end
        for (int k = 0; k < LANES; k++) if (pct[k] > top) top = pct[k];
      end else begin
        for (int k = 0; k < LANES; k++) pct[k] = 0;
      end
      for (int k = 0; k < LANES; k++) begin
        r.lane = LANE_W'(k);
        r.percent = PCT_W'(pct[k]);
        r.component = (!zero && top != 0) ? COMP_W'(pct[k] * FULL / top) : '0;
        r.zero_sum = zero;
        r.last = (k == LANES - 1);
        pending.push_back(r);
      end
    endfunction

    function void check_result(lane_res_t got_r);
      lane_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result lane=%0d pct=%0d", $time, got_r.lane,
                 got_r.percent);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got_r.lane !== e.lane) begin
        $display("%0t: lane exp %0d got %0d", $time, e.lane, got_r.lane);
        errors++;
      end
      if (got_r.percent !== e.percent) begin
        $display("%0t: percent exp %0d got %0d", $time, e.percent, got_r.percent);
        errors++;
      end
      if (got_r.component !== e.component) begin
        $display("%0t: component exp %0d got %0d", $time, e.component,
                 got_r.component);
        errors++;
      end
      if (got_r.zero_sum !== e.zero_sum) begin
        $display("%0t: zero_sum exp %0b got %0b", $time, e.zero_sum, got_r.zero_sum);
        errors++;
      end
      if (got_r.last !== e.last) begin
        $display("%0t: last exp %0b got %0b", $time, e.last, got_r.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic push = 0;
  logic pop = 0;
  logic full, empty;
  logic [SHARE_W-1:0] in_share_0 = 0, in_share_1 = 0, in_share_2 = 0;
  logic [SHARE_W-1:0] in_share_3 = 0, in_share_4 = 0, in_share_5 = 0;
  logic [LANE_W-1:0] out_lane;
  logic [PCT_W-1:0] out_percent;
  logic [COMP_W-1:0] out_component;
  logic out_zero_sum, out_last;

  mix_scoreboard sb = new();
  bit quiet = 0;
  int hold_cycles = 0;

  mix_percent_normalizer #(.LANES(LANES), .FULL_SCALE(FULL)) dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_share_0(in_share_0), .in_share_1(in_share_1), .in_share_2(in_share_2),
    .in_share_3(in_share_3), .in_share_4(in_share_4), .in_share_5(in_share_5),
    .empty(empty), .pop(pop), .out_lane(out_lane), .out_percent(out_percent),
    .out_component(out_component), .out_zero_sum(out_zero_sum),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result side: sample at rising edge, change pop at falling edge
  always @(posedge clk) begin
    lane_res_t r;
    if (rst_n && pop && !empty) begin
      r.lane = out_lane;
      r.percent = out_percent;
      r.component = out_component;
      r.zero_sum = out_zero_sum;
      r.last = out_last;
      sb.check_result(r);
    end
  end

  initial begin
    int idle;
    idle = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 0;
      end else if (idle > 0) begin
        idle--;
        pop <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        idle = $urandom_range(1, 9) - 1;
        pop <= 0;
      end else begin
        pop <= 1;
      end
    end
  end

  task automatic send_set(logic [SHARE_W-1:0] sh[MAX_LANES]);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_share_0 <= sh[0];
    in_share_1 <= sh[1];
    in_share_2 <= sh[2];
    in_share_3 <= sh[3];
    in_share_4 <= sh[4];
    in_share_5 <= sh[5];
    push <= 1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_set(sh);
    @(negedge clk);
  endtask

  task automatic send_fill(int mode);
    logic [SHARE_W-1:0] sh[MAX_LANES];
    for (int k = 0; k < MAX_LANES; k++) begin
      case (mode)
        0: sh[k] = SHARE_W'($urandom_range(0, 255));
        1: sh[k] = ($urandom_range(0, 2) == 0) ? '0 : SHARE_W'($urandom_range(0, 255));
        2: sh[k] = SHARE_W'($urandom_range(0, 3));
        default: sh[k] = ($urandom_range(0, 1) == 0) ? 8'd255 :
                         SHARE_W'($urandom_range(0, 255));
      endcase
    end
    send_set(sh);
  endtask

  task automatic wait_drained();
    push <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [SHARE_W-1:0] sh[MAX_LANES];
    logic [SHARE_W-1:0] dir[12][MAX_LANES] = '{
      '{0, 0, 0, 0, 0, 0},
      '{255, 255, 255, 255, 255, 255},
      '{1, 0, 0, 0, 0, 0},
      '{0, 0, 0, 1, 0, 0},
      '{1, 1, 1, 0, 7, 9},
      '{1, 1, 1, 1, 0, 0},
      '{255, 0, 0, 0, 255, 255},
      '{1, 2, 0, 0, 0, 0},
      '{0, 0, 0, 0, 255, 1},
      '{3, 3, 3, 3, 0, 0},
      '{85, 170, 1, 0, 0, 0},
      '{1, 1, 1, 97, 0, 0}};
    repeat (6) @(negedge clk);
    rst_n <= 1;
    foreach (dir[i]) begin
      for (int k = 0; k < MAX_LANES; k++) sh[k] = dir[i][k];
      send_set(sh);
    end
    // stall the result side so the block backs up
    @(negedge clk);
    hold_cycles = 300;
    for (int i = 0; i < 8; i++) send_fill(0);
    wait_drained();
    for (int i = 0; i < 140; i++) begin
      if (i == 110) quiet = 1;
      send_fill($urandom_range(0, 3));
      if (i == 60) wait_drained();
    end
    wait_drained();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("mix_percent_normalizer verification clean");
    end else begin
      $display("mix_percent_normalizer verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("mix_percent_normalizer verification failed");
    $finish;
  end
endmodule
